/* rtl/s256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, command and status structures, and the SHA-256 constant tables.
// ----------------------------------------------------------------------------
package s256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN
    } t_state;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } t_byte_src;

    typedef struct packed {
        logic      shift_byte;
        t_byte_src src;
        logic [2:0] len_idx;
        logic      count_bits;
        logic      load_work;
        logic      run_round;
        logic [5:0] round_idx;
        logic      add_chain;
        logic      finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] LEN_FILL      = 6'd56;
    localparam logic [5:0] ROUND_LAST    = 6'd63;
    localparam logic [2:0] WORD_LAST     = 3'd7;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;
            default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

/* rtl/s256_if.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher channels
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface s256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

interface s256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

/* rtl/s256_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, the 64 compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
module s256_ctrl
    import s256_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    s256_in_if.sink i_in,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_round, n_round;
    logic       r_eom_pend, n_eom_pend;
    logic       r_pad_phase, n_pad_phase;
    logic       r_final, n_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_round     <= '0;
            r_eom_pend  <= 1'b0;
            r_pad_phase <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_round     <= n_round;
            r_eom_pend  <= n_eom_pend;
            r_pad_phase <= n_pad_phase;
            r_final     <= n_final;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_round     = r_round;
        n_eom_pend  = r_eom_pend;
        n_pad_phase = r_pad_phase;
        n_final     = r_final;
        o_cmd       = '0;
        o_cmd.round_idx = r_round;
        o_cmd.len_idx   = r_fill[2:0];
        i_in.ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.has_byte) begin
                        o_cmd.shift_byte = 1'b1;
                        o_cmd.src        = SRC_DATA;
                        o_cmd.count_bits = 1'b1;
                        n_fill           = r_fill + 6'd1;
                        if (r_fill == FILL_LAST) begin
                            o_cmd.load_work = 1'b1;
                            n_eom_pend      = i_in.end_of_message;
                            n_state         = ST_ROUND;
                        end else if (i_in.end_of_message) begin
                            n_state = ST_PAD_MARK;
                        end
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                o_cmd.shift_byte = 1'b1;
                o_cmd.src        = SRC_MARK;
                n_fill           = r_fill + 6'd1;
                n_pad_phase      = 1'b1;
                n_eom_pend       = 1'b0;
                if (r_fill == FILL_LAST) begin
                    o_cmd.load_work = 1'b1;
                    n_state         = ST_ROUND;
                end else begin
                    n_state = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (r_fill == LEN_FILL) begin
                    n_state = ST_PAD_LEN;
                end else begin
                    o_cmd.shift_byte = 1'b1;
                    o_cmd.src        = SRC_ZERO;
                    n_fill           = r_fill + 6'd1;
                    if (r_fill == FILL_LAST) begin
                        o_cmd.load_work = 1'b1;
                        n_state         = ST_ROUND;
                    end
                end
            end
            ST_PAD_LEN: begin
                o_cmd.shift_byte = 1'b1;
                o_cmd.src        = SRC_LEN;
                n_fill           = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    o_cmd.load_work = 1'b1;
                    n_final         = 1'b1;
                    n_state         = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.run_round = 1'b1;
                n_round         = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_final) begin
                    // The digest waits here until the previous one has drained.
                    if (!i_status.out_busy) begin
                        o_cmd.finish = 1'b1;
                        n_final      = 1'b0;
                        n_pad_phase  = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.add_chain = 1'b1;
                    if (r_pad_phase) begin
                        n_state = ST_PAD_ZERO;
                    end else if (r_eom_pend) begin
                        n_state = ST_PAD_MARK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/s256_dp.sv */
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block shift register doubling as the schedule window, round logic, chaining
// values, bit counter and the digest output register.
// ----------------------------------------------------------------------------
module s256_dp
    import s256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_status     o_status,
    s256_out_if.source  o_out
);

    logic [31:0] r_win   [16];
    logic [31:0] r_work  [8];
    logic [31:0] r_chain [8];
    logic [31:0] r_dig   [8];
    logic [63:0] r_msg_bits;
    logic [2:0]  r_ocnt;
    logic        r_obusy;

    logic [7:0]  byte_in;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic        out_acc;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        case (i_cmd.src)
            SRC_DATA: byte_in = i_data_byte;
            SRC_MARK: byte_in = PAD_MARK_BYTE;
            SRC_ZERO: byte_in = '0;
            SRC_LEN:  byte_in = r_msg_bits[{~i_cmd.len_idx, 3'b000} +: 8];
            default:  byte_in = '0;
        endcase
    end

    always_comb begin
        sched_new = r_win[0]
                  + (rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3))
                  + r_win[9]
                  + (rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10));
        t1 = r_work[7]
           + (rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25))
           + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]))
           + round_k(i_cmd.round_idx)
           + r_win[0];
        t2 = (rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22))
           + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]));
    end

    // The window holds the block with its first byte at the top of word 0.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_byte) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], byte_in};
        end else if (i_cmd.run_round) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= sched_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (i_cmd.run_round) begin
            r_work[0] <= t1 + t2;
            r_work[1] <= r_work[0];
            r_work[2] <= r_work[1];
            r_work[3] <= r_work[2];
            r_work[4] <= r_work[3] + t1;
            r_work[5] <= r_work[4];
            r_work[6] <= r_work[5];
            r_work[7] <= r_work[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
            r_msg_bits <= '0;
        end else begin
            if (i_cmd.finish) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= init_hash(3'(i));
                end
            end else if (i_cmd.add_chain) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end
            if (i_cmd.finish) begin
                r_msg_bits <= '0;
            end else if (i_cmd.count_bits) begin
                r_msg_bits <= r_msg_bits + 64'd8;
            end
        end
    end

    assign out_acc = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= r_chain[i] + r_work[i];
            end
        end else if (out_acc) begin
            for (int i = 0; i < 7; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obusy <= 1'b0;
            r_ocnt  <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_obusy <= 1'b1;
            end else if (out_acc && r_ocnt == WORD_LAST) begin
                r_obusy <= 1'b0;
            end
            if (out_acc) begin
                r_ocnt <= r_ocnt + 3'd1;
            end
        end
    end

    assign o_out.valid       = r_obusy;
    assign o_out.digest_word = r_dig[0];
    assign o_out.word_index  = r_ocnt;
    assign o_out.last_word   = (r_ocnt == WORD_LAST);
    assign o_status.out_busy = r_obusy;

endmodule

/* rtl/sha256_byte_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher core
// A byte not completing a block is taken without a stall; one completing a
// block stalls the input through the 64 rounds and the chaining add. An end
// mark pads byte by byte, input held off, compressing one or two more blocks;
// the first digest word follows their rounds and final add, then one word per
// cycle while ready is high. Synchronous active-low reset restores the
// initial chaining values and clears the length and fill counts.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core
    import s256_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    s256_in_if.sink    i_in,
    s256_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    s256_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (status),
        .o_cmd    (cmd)
    );

    s256_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_in.data_byte),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule

/* rtl/s256_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher port checker
// Checks digest word sequencing and input blocking seen at the core's ports.
// ----------------------------------------------------------------------------
module s256_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_end,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_index,
    input logic       i_out_last
);

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && i_out_index == $past(i_out_index) + 3'd1))
        else $error("digest words not delivered in order");

    a_digest_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("new digest followed the last word too soon");

    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_end) |=> !i_in_ready)
        else $error("input taken while padding an ended message");

endmodule

bind sha256_byte_stream_hasher_core s256_checker u_s256_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_end    (i_in.end_of_message),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.word_index),
    .i_out_last  (o_out.last_word)
);
